/* hw/rtl/wheel6_prime_sieve_defines.svh */
// wheel6_prime_sieve_defines.svh: assertion macros for the wheel-6 sieve checker
// depends on nothing; the including module provides clk and rst_n
`ifndef WHEEL6_PRIME_SIEVE_DEFINES_SVH
`define WHEEL6_PRIME_SIEVE_DEFINES_SVH

// property checked out of reset
`define W6PS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define W6PS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/w6ps_pkg.sv */
// w6ps_pkg: word types and fixed constants of the wheel-6 prime sieve
// no dependencies
package w6ps_pkg;

  localparam int CFG_W   = 17;
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 18;

  localparam logic [CFG_W-1:0] COUNT_RESET = 17'h10000;

  localparam logic KIND_SIEVE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_prime;
    logic               done_res;
    logic               out_of_range;
  } out_word_t;

endpackage

/* hw/rtl/wheel6_prime_sieve.sv */
// wheel6_prime_sieve: top level of the wheel-6 sieve of eratosthenes with query port
// depends on w6ps_pkg; one internal flag memory with registered read
//
// Candidate index x stands for the number 3(x+2)-1-(x odd), i.e. 5, 7, 11, 13, 17, ...
// A sieve word (kind 0) marks the first n = min(candidate_count, MAX_ENTRIES) flags
// prime, then walks the indices in order and, for every surviving m with m*m not
// above the last candidate, clears the two multiple chains of m (stride 2m indices),
// and answers with one done word. A query word (kind 1) answers with the value and
// prime flag of one index, or flags the index out of range when it is not below n.
// Queries stream at one word per clock while the result channel does not stall. The
// edge that takes a query starts the flag read; the answer then moves into the output
// register once that register can take a word. At most one query sits in the memory
// read stage and one in the output register.
// A sieve occupies the single flag memory, and no input word is taken until it has
// handed out its done word. No clearing pass follows reset: a high-water count of
// filled entries makes never-written entries read as prime.
module wheel6_prime_sieve #(
  parameter int MAX_ENTRIES = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  w6ps_pkg::in_word_t             in_word,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output w6ps_pkg::out_word_t            out_word,
  // candidate_count register
  input  logic                           cfg_wr_en,
  input  logic [w6ps_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int AW   = $clog2(MAX_ENTRIES);           // flag address width
  localparam int NW   = AW + 1;                        // counts up to MAX_ENTRIES
  localparam int VW   = AW + 2;                        // candidate value width
  localparam int PW   = AW + 4;                        // chain position width
  localparam int SQW  = 2 * VW;                        // squared value width
  localparam int CMPW = (NW > w6ps_pkg::CFG_W) ? NW : w6ps_pkg::CFG_W;
  localparam int QW   = (AW > w6ps_pkg::INDEX_W) ? AW : w6ps_pkg::INDEX_W;

  typedef enum logic [2:0] {
    ST_IDLE,   // queries stream, sieve may start
    ST_FILL,   // write ones over the first n flags
    ST_RD,     // bound check, read flag of scan index
    ST_SQ,     // square candidate, capture flag
    ST_CHK,    // compare square against last candidate
    ST_CH1,    // clear first multiple chain
    ST_CH2,    // clear second multiple chain
    ST_DONE    // hand out the done word
  } state_t;

  // candidate value of index x: 3(x+2)-1-(x odd)
  function automatic logic [VW-1:0] cand_f(input logic [NW-1:0] x);
    logic [VW-1:0] t;
    t = VW'(x) + VW'(2);
    return (t << 1) + t - VW'(1) - VW'(x[0]);
  endfunction

  state_t                  state_r;
  logic [w6ps_pkg::CFG_W-1:0] cfg_count_r;
  logic [NW-1:0]           hw_r;       // entries below this were filled since reset
  logic [NW-1:0]           n_r;        // effective count of the running sieve
  logic [NW-1:0]           ix_r;       // fill pointer, then scan index
  logic [VW-1:0]           last_r;     // last candidate in use
  logic [VW-1:0]           v_r;        // candidate at scan index
  logic [SQW-1:0]          sq_r;
  logic                    flag_r;
  logic [PW-1:0]           w1_r;
  logic [PW-1:0]           w2_r;
  logic [PW-1:0]           step_r;

  // query read stage
  logic                    q_valid_r;
  logic [AW-1:0]           q_addr_r;
  logic [w6ps_pkg::VALUE_W-1:0] q_value_r;
  logic                    q_oor_r;
  logic                    q_hi_r;     // index never filled, reads as prime

  // output register
  logic                    out_valid_r;
  w6ps_pkg::out_word_t     out_word_r;

  // flag memory
  logic                    flag_mem [0:MAX_ENTRIES-1];
  logic                    rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic                    wr_data;

  logic                    adv;        // output register can take a word
  logic                    accept;
  logic [CMPW-1:0]         count_ext;
  logic [NW-1:0]           n_eff;
  logic [QW-1:0]           idx_ext;
  logic                    in_oor;
  logic                    in_hi;
  logic [w6ps_pkg::VALUE_W-1:0] in_value;
  logic [w6ps_pkg::VALUE_W-1:0] idx_plus2;
  logic [VW-1:0]           k_c;
  logic [PW-1:0]           n_pos;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // a sieve must wait until the pending query has left the read stage
  assign in_stall = (state_r != ST_IDLE) || (q_valid_r && !adv) ||
                    (q_valid_r && in_valid && (in_word.kind == w6ps_pkg::KIND_SIEVE));
  assign accept   = in_valid && !in_stall;

  // effective count, clipped to the storage depth
  assign count_ext = CMPW'(cfg_count_r);
  assign n_eff     = (count_ext > CMPW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(count_ext);

  assign idx_ext   = QW'(in_word.index);
  assign in_oor    = CMPW'(in_word.index) >= CMPW'(n_eff);
  assign in_hi     = CMPW'(in_word.index) >= CMPW'(hw_r);
  assign idx_plus2 = w6ps_pkg::VALUE_W'(in_word.index) + w6ps_pkg::VALUE_W'(2);
  assign in_value  = (idx_plus2 << 1) + idx_plus2 - w6ps_pkg::VALUE_W'(1)
                     - w6ps_pkg::VALUE_W'(in_word.index[0]);

  // k of m = 6k -/+ 1 is half the index plus one
  assign k_c   = VW'(ix_r >> 1) + VW'(1);
  assign n_pos = PW'(n_r);

  // memory port selection
  always_comb begin
    if (state_r == ST_RD) begin
      rd_addr = ix_r[AW-1:0];
    end else if (q_valid_r && !adv) begin
      rd_addr = q_addr_r;       // re-read while the query is held
    end else begin
      rd_addr = idx_ext[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ix_r[AW-1:0];
    wr_data = 1'b1;
    case (state_r)
      ST_FILL: begin
        wr_en = 1'b1;
      end
      ST_CH1: begin
        wr_en   = w1_r < n_pos;
        wr_addr = w1_r[AW-1:0];
        wr_data = 1'b0;
      end
      ST_CH2: begin
        wr_en   = w2_r < n_pos;
        wr_addr = w2_r[AW-1:0];
        wr_data = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      flag_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= flag_mem[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= w6ps_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      cfg_count_r <= cfg_wr_data;
    end
  end

  // sequencer, query stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hw_r        <= '0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // query read stage: take a new query, or empty once the answer moves on
      if (accept && (in_word.kind == w6ps_pkg::KIND_QUERY)) begin
        q_valid_r <= 1'b1;
        q_addr_r  <= idx_ext[AW-1:0];
        q_value_r <= in_value;
        q_oor_r   <= in_oor;
        q_hi_r    <= in_hi;
      end else if (adv) begin
        q_valid_r <= 1'b0;
      end

      // output register: query answer, done word, or drain
      if (q_valid_r && adv) begin
        out_valid_r             <= 1'b1;
        out_word_r.value        <= q_oor_r ? '0 : q_value_r;
        out_word_r.is_prime     <= !q_oor_r && (q_hi_r || rd_data_r);
        out_word_r.done_res     <= 1'b0;
        out_word_r.out_of_range <= q_oor_r;
      end else if ((state_r == ST_DONE) && adv) begin
        // the query stage is empty here, so the output register is ours
        out_valid_r             <= 1'b1;
        out_word_r.value        <= '0;
        out_word_r.is_prime     <= 1'b0;
        out_word_r.done_res     <= 1'b1;
        out_word_r.out_of_range <= 1'b0;
      end else if (adv) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept && (in_word.kind == w6ps_pkg::KIND_SIEVE)) begin
            n_r  <= n_eff;
            ix_r <= '0;
            if (n_eff == '0) begin
              state_r <= ST_DONE;
            end else begin
              if (n_eff > hw_r) begin
                hw_r <= n_eff;
              end
              state_r <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          last_r <= cand_f(n_r - NW'(1));
          if (ix_r == n_r - NW'(1)) begin
            ix_r    <= '0;
            state_r <= ST_RD;
          end else begin
            ix_r <= ix_r + NW'(1);
          end
        end
        ST_RD: begin
          if (ix_r >= n_r) begin
            state_r <= ST_DONE;
          end else begin
            v_r     <= cand_f(ix_r);
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_r    <= SQW'(v_r) * SQW'(v_r);
          flag_r  <= rd_data_r;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (sq_r > SQW'(last_r)) begin
            state_r <= ST_DONE;
          end else if (flag_r) begin
            step_r <= PW'(v_r) << 1;
            if (!ix_r[0]) begin
              w1_r <= (PW'(v_r - k_c) << 1) - PW'(1);
              w2_r <= (PW'(v_r + k_c) << 1) - PW'(2);
            end else begin
              w1_r <= (PW'(v_r - k_c) << 1) - PW'(2);
              w2_r <= (PW'(v_r + k_c) << 1) - PW'(1);
            end
            state_r <= ST_CH1;
          end else begin
            ix_r    <= ix_r + NW'(1);
            state_r <= ST_RD;
          end
        end
        ST_CH1: begin
          if (w1_r < n_pos) begin
            w1_r <= w1_r + step_r;
          end else begin
            state_r <= ST_CH2;
          end
        end
        ST_CH2: begin
          if (w2_r < n_pos) begin
            w2_r <= w2_r + step_r;
          end else begin
            ix_r    <= ix_r + NW'(1);
            state_r <= ST_RD;
          end
        end
        ST_DONE: begin
          // done word goes out with the output register above
          if (adv) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/w6ps_checker.sv */
// w6ps_checker: port-level assertions for wheel6_prime_sieve, bound to the top level
// depends on w6ps_pkg and wheel6_prime_sieve_defines.svh
`include "wheel6_prime_sieve_defines.svh"

module w6ps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input w6ps_pkg::in_word_t         in_word,
  input logic                       out_valid,
  input logic                       out_stall,
  input w6ps_pkg::out_word_t        out_word,
  input logic                       cfg_wr_en,
  input logic [w6ps_pkg::CFG_W-1:0] cfg_wr_data
);

  logic done_clean;
  logic oor_clean;

  assign done_clean = (out_word.value == '0) && !out_word.is_prime &&
                      !out_word.out_of_range;
  assign oor_clean  = (out_word.value == '0) && !out_word.is_prime &&
                      !out_word.done_res;

  // a done word carries nothing else
  `W6PS_ASSERT(a_done_clean, out_valid && out_word.done_res |-> done_clean, "done word has data")

  // an out-of-range answer is neither prime nor a done word
  `W6PS_ASSERT(a_oor_clean, out_valid && out_word.out_of_range |-> oor_clean, "oor word has data")

  // reset empties the result channel
  `W6PS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result word survives reset")

  // a stalled result word holds
  `W6PS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "word moved")

endmodule

bind wheel6_prime_sieve w6ps_checker u_w6ps_checker (.*);
